// ----- src/pac_pkg.sv -----
package pac_pkg;

  localparam int unsigned SAMPLE_W     = 16;
  localparam int unsigned ADC_W        = 12;
  localparam int unsigned ERR_W        = 13;
  localparam int unsigned ADC_SPAN     = 4096;
  localparam int unsigned RANGE_MARGIN = 500;

  localparam logic [ADC_W-1:0] ADC_CLAMP = 12'hFFF;
  // upper IR limit base for range one
  localparam logic [ADC_W-1:0] R1_BASE   = ADC_W'(ADC_SPAN - RANGE_MARGIN);

  typedef enum logic [1:0] {
    CMD_POLL   = 2'd0,
    CMD_FIRST  = 2'd1,
    CMD_ENABLE = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_FAR   = 2'd1,
    ACT_CLOSE = 2'd2,
    ACT_AGAIN = 2'd3
  } act_e;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_FAR   = 2'd1,
    EV_CLOSE = 2'd2
  } ev_e;

  typedef enum logic [2:0] {
    REG_UP_SWITCH   = 3'd0,
    REG_DOWN_SWITCH = 3'd1,
    REG_LOW_R0      = 3'd2,
    REG_HIGH_R0     = 3'd3,
    REG_LOW_R1      = 3'd4,
    REG_HIGH_R1     = 3'd5,
    REG_ERR_R0      = 3'd6,
    REG_ERR_R1      = 3'd7
  } reg_e;

  typedef struct packed {
    logic [ADC_W-1:0] up_switch_limit;
    logic [ADC_W-1:0] down_switch_limit;
    logic [ADC_W-1:0] low_thresh_r0;
    logic [ADC_W-1:0] high_thresh_r0;
    logic [ADC_W-1:0] low_thresh_r1;
    logic [ADC_W-1:0] high_thresh_r1;
    logic [ERR_W-1:0] err_limit_r0;
    logic [ERR_W-1:0] err_limit_r1;
  } cfg_t;

  typedef struct packed {
    logic gain_range;
    logic range_switched;
    ev_e  previous_event;
  } state_t;

  typedef struct packed {
    act_e action;
    logic next_range;
  } result_t;

endpackage

// ----- src/pac_if.sv -----
interface pac_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [15:0] ir_sample;
  logic [15:0] prox_sample;

  modport source (output valid, command, ir_sample, prox_sample, input ready);
  modport sink   (input valid, command, ir_sample, prox_sample, output ready);
endinterface

interface pac_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic       next_range;

  modport source (output valid, action, next_range, input ready);
  modport sink   (input valid, action, next_range, output ready);
endinterface

interface pac_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [12:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/pac_cfg_regs.sv -----
module pac_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  pac_cfg_if.sink       cfg_i,
  output pac_pkg::cfg_t cfg_o
);
  import pac_pkg::*;

  cfg_t cfg_q;
  reg_e idx;

  assign cfg_i.ready = 1'b1;
  assign idx         = reg_e'(cfg_i.index);
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.up_switch_limit   <= 12'd1096;
      cfg_q.down_switch_limit <= 12'd194;
      cfg_q.low_thresh_r0     <= 12'd2400;
      cfg_q.high_thresh_r0    <= 12'd2500;
      cfg_q.low_thresh_r1     <= 12'd95;
      cfg_q.high_thresh_r1    <= 12'd100;
      cfg_q.err_limit_r0      <= 13'd4096;
      cfg_q.err_limit_r1      <= 13'd50;
    end else if (cfg_i.valid) begin
      case (idx)
        REG_UP_SWITCH:   cfg_q.up_switch_limit   <= cfg_i.data[ADC_W-1:0];
        REG_DOWN_SWITCH: cfg_q.down_switch_limit <= cfg_i.data[ADC_W-1:0];
        REG_LOW_R0:      cfg_q.low_thresh_r0     <= cfg_i.data[ADC_W-1:0];
        REG_HIGH_R0:     cfg_q.high_thresh_r0    <= cfg_i.data[ADC_W-1:0];
        REG_LOW_R1:      cfg_q.low_thresh_r1     <= cfg_i.data[ADC_W-1:0];
        REG_HIGH_R1:     cfg_q.high_thresh_r1    <= cfg_i.data[ADC_W-1:0];
        REG_ERR_R0:      cfg_q.err_limit_r0      <= cfg_i.data;
        REG_ERR_R1:      cfg_q.err_limit_r1      <= cfg_i.data;
        default: ;
      endcase
    end
  end

endmodule

// ----- src/pac_classify.sv -----
module pac_classify (
  input  pac_pkg::cfg_t    cfg_i,
  input  pac_pkg::state_t  state_i,
  input  logic [1:0]       command_i,
  input  logic [15:0]      ir_sample_i,
  input  logic [15:0]      prox_sample_i,
  output pac_pkg::state_t  state_o,
  output pac_pkg::result_t result_o
);
  import pac_pkg::*;

  cmd_e             cmd;
  logic [ADC_W-1:0] ir;
  logic [ADC_W-1:0] ps;
  logic [ADC_W:0]   diff;
  logic [ADC_W-1:0] low;
  logic [ADC_W-1:0] high;
  logic [ERR_W-1:0] err;
  logic             above;
  logic             below;
  logic             sw;
  logic             do_switch;
  ev_e              ev;

  assign cmd = cmd_e'(command_i);

  // clamp both readings to the ADC span
  assign ir = (|ir_sample_i[SAMPLE_W-1:ADC_W])   ? ADC_CLAMP : ir_sample_i[ADC_W-1:0];
  assign ps = (|prox_sample_i[SAMPLE_W-1:ADC_W]) ? ADC_CLAMP : prox_sample_i[ADC_W-1:0];

  assign above = state_i.gain_range
               ? ((cfg_i.high_thresh_r1 <= R1_BASE) && (ir > (R1_BASE - cfg_i.high_thresh_r1)))
               : (ir > cfg_i.up_switch_limit);
  assign below = state_i.gain_range && (ir < cfg_i.down_switch_limit);

  assign sw        = (cmd == CMD_FIRST) ? 1'b0 : state_i.range_switched;
  assign do_switch = !sw && ((above && !state_i.gain_range) || (!above && below));

  assign low  = state_i.gain_range ? cfg_i.low_thresh_r1  : cfg_i.low_thresh_r0;
  assign high = state_i.gain_range ? cfg_i.high_thresh_r1 : cfg_i.high_thresh_r0;
  assign err  = state_i.gain_range ? cfg_i.err_limit_r1   : cfg_i.err_limit_r0;

  assign diff = {1'b0, ps} - {1'b0, ir};

  always_comb begin
    if (diff[ADC_W] || ({1'b0, diff[ADC_W-1:0]} > err)) begin
      ev = EV_NONE;
    end else if (diff[ADC_W-1:0] > high) begin
      ev = EV_CLOSE;
    end else if (diff[ADC_W-1:0] < low) begin
      ev = EV_FAR;
    end else begin
      ev = EV_NONE;
    end
  end

  always_comb begin
    state_o             = state_i;
    result_o.action     = ACT_NONE;
    result_o.next_range = state_i.gain_range;
    case (cmd)
      CMD_ENABLE: begin
        state_o.gain_range  = 1'b0;
        result_o.next_range = 1'b0;
      end
      CMD_POLL, CMD_FIRST: begin
        state_o.range_switched = sw;
        if (do_switch) begin
          // drop the prox reading and measure again at the new range
          state_o.gain_range     = ~state_i.gain_range;
          state_o.range_switched = 1'b1;
          result_o.action        = ACT_AGAIN;
          result_o.next_range    = ~state_i.gain_range;
        end else begin
          state_o.previous_event = ev;
          case (ev)
            EV_FAR:   result_o.action = ACT_FAR;
            EV_CLOSE: result_o.action = (state_i.previous_event == EV_CLOSE) ? ACT_CLOSE
                                                                             : ACT_AGAIN;
            default:  result_o.action = ACT_NONE;
          endcase
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- src/proximity_autorange_classifier_unit.sv -----
// Proximity auto-range classifier.
// Channels: in_i carries one transaction per measurement (command, ambient IR
// reading, proximity reading); out_o returns exactly one transaction per input
// (action and the gain range to use next); cfg_i writes the eight threshold and
// limit registers by index and is always ready. Write configuration only while
// no transaction is in flight.
// Pipeline: an accepted input is held in the input register, classified
// combinationally from there and moves into the result register, which drives
// out_o.valid, as soon as that register is free or draining. Throughput is one
// transaction per cycle while out_o.ready does not stall the result register;
// the rate rests on the combinational update of gain range, switch flag and
// previous event between the input register and the result register.
// Reset: gain range zero, no switch in this poll, previous event none, both
// pipeline registers empty and all configuration registers at board defaults.
// Stall: while out_o.ready is low the result register holds, the input register
// keeps one more transaction, and in_i.ready falls once both are full.
module proximity_autorange_classifier_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  pac_cfg_if.sink   cfg_i,
  pac_in_if.sink    in_i,
  pac_out_if.source out_o
);
  import pac_pkg::*;

  cfg_t    cfg;
  state_t  state_q;
  state_t  state_d;
  result_t res_d;
  result_t res_q;

  logic        iv_q, iv_d;
  logic        ov_q, ov_d;
  logic [1:0]  cmd_q;
  logic [15:0] ir_q;
  logic [15:0] ps_q;
  logic        in_acc;
  logic        adv;

  pac_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  pac_classify u_classify (
    .cfg_i         (cfg),
    .state_i       (state_q),
    .command_i     (cmd_q),
    .ir_sample_i   (ir_q),
    .prox_sample_i (ps_q),
    .state_o       (state_d),
    .result_o      (res_d)
  );

  // advance the held transaction when the result register is free or draining
  assign adv        = iv_q && (!ov_q || out_o.ready);
  assign in_i.ready = !iv_q || adv;
  assign in_acc     = in_i.valid && in_i.ready;

  assign iv_d = in_acc || (iv_q && !adv);
  assign ov_d = adv || (ov_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iv_q    <= 1'b0;
      ov_q    <= 1'b0;
      state_q <= '{gain_range: 1'b0, range_switched: 1'b0, previous_event: EV_NONE};
    end else begin
      iv_q <= iv_d;
      ov_q <= ov_d;
      if (adv) begin
        state_q <= state_d;
      end
    end
  end

  // payload registers: no reset
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q <= in_i.command;
      ir_q  <= in_i.ir_sample;
      ps_q  <= in_i.prox_sample;
    end
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid      = ov_q;
  assign out_o.action     = res_q.action;
  assign out_o.next_range = res_q.next_range;

`ifndef SYNTHESIS
  // a confirmed close needs a close event left by the previous transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && res_d.action == ACT_CLOSE) |-> (state_q.previous_event == EV_CLOSE))
    else $error("close reported without a preceding close event");

  // once switched within a poll the range only changes by enable or a new poll
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && state_q.range_switched && cmd_q != CMD_FIRST && cmd_q != CMD_ENABLE)
      |-> (state_d.gain_range == state_q.gain_range))
    else $error("second range switch within one poll");

  // input back-pressure only when both stages are full and the sink stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (iv_q && ov_q && !out_o.ready))
    else $error("input stalled without a full pipeline");

  // the result register reports the range that the state holds afterwards
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> (res_q.next_range == state_q.gain_range))
    else $error("next range differs from the stored gain range");
`endif

endmodule

// ----- verif/proximity_autorange_classifier_unit_tb.sv -----
`timescale 1ns / 100ps

module proximity_autorange_classifier_unit_tb;
  import pac_pkg::*;

  // Hard stop: the slowest legal run ends well before this limit
  localparam int CYCLE_LIMIT = 200000;

  logic clk_i = 1'b0;
  logic rst_ni;

  pac_cfg_if cfg_bus ();
  pac_in_if  in_bus ();
  pac_out_if out_bus ();

  proximity_autorange_classifier_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  always #4 clk_i = ~clk_i;

  // Predictor state: our own copy of the range logic and the threshold registers
  cfg_t    cfg_model;
  logic    range_sel;
  logic    switched_in_poll;
  ev_e     prev_ev;

  // One entry per accepted sample; the block answers every sample exactly once
  result_t expected_verdicts[$];

  int mismatches   = 0;
  int items_sent   = 0;
  int cycle_count  = 0;
  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int hold_cycles  = 0;

  function automatic cfg_t make_thresholds(int up, int down, int lo0, int hi0,
                                           int lo1, int hi1, int err0, int err1);
    cfg_t c;
    c.up_switch_limit   = ADC_W'(up);
    c.down_switch_limit = ADC_W'(down);
    c.low_thresh_r0     = ADC_W'(lo0);
    c.high_thresh_r0    = ADC_W'(hi0);
    c.low_thresh_r1     = ADC_W'(lo1);
    c.high_thresh_r1    = ADC_W'(hi1);
    c.err_limit_r0      = ERR_W'(err0);
    c.err_limit_r1      = ERR_W'(err1);
    return c;
  endfunction

  // Work out the verdict for one sample pair and advance the predictor state.
  function automatic result_t classify_sample(cmd_e cmd, logic [15:0] ir_raw,
                                              logic [15:0] prox_raw);
    result_t r;
    int      ir;
    int      px;
    int      diff;
    int      lo;
    int      hi;
    int      err;
    int      upper_r1;
    bit      above;
    ev_e     ev;
    // Clamp both readings to the 12-bit converter span
    ir = (int'(ir_raw) > int'(ADC_CLAMP)) ? int'(ADC_CLAMP) : int'(ir_raw);
    px = (int'(prox_raw) > int'(ADC_CLAMP)) ? int'(ADC_CLAMP) : int'(prox_raw);
    r.action     = ACT_NONE;
    r.next_range = range_sel;
    // Sensor enable drops back to range zero and touches nothing else
    if (cmd == CMD_ENABLE) begin
      range_sel    = 1'b0;
      r.next_range = 1'b0;
      return r;
    end
    if (cmd == CMD_UNUSED) return r;
    if (cmd == CMD_FIRST) switched_in_poll = 1'b0;
    // In range one the upper limit vanishes once the high threshold passes the base
    upper_r1 = int'(ADC_SPAN - RANGE_MARGIN) - int'(cfg_model.high_thresh_r1);
    if (!range_sel) above = ir > int'(cfg_model.up_switch_limit);
    else            above = (upper_r1 >= 0) && (ir > upper_r1);
    // At most one switch per poll; a switch discards the proximity reading
    if (above) begin
      if (!switched_in_poll && !range_sel) begin
        range_sel        = 1'b1;
        switched_in_poll = 1'b1;
        r.action         = ACT_AGAIN;
        r.next_range     = 1'b1;
        return r;
      end
    end else if (range_sel && ir < int'(cfg_model.down_switch_limit)) begin
      if (!switched_in_poll) begin
        range_sel        = 1'b0;
        switched_in_poll = 1'b1;
        r.action         = ACT_AGAIN;
        r.next_range     = 1'b0;
        return r;
      end
    end
    if (!range_sel) begin
      lo  = int'(cfg_model.low_thresh_r0);
      hi  = int'(cfg_model.high_thresh_r0);
      err = int'(cfg_model.err_limit_r0);
    end else begin
      lo  = int'(cfg_model.low_thresh_r1);
      hi  = int'(cfg_model.high_thresh_r1);
      err = int'(cfg_model.err_limit_r1);
    end
    diff = px - ir;
    if (diff < 0 || diff > err) ev = EV_NONE;
    else if (diff > hi)         ev = EV_CLOSE;
    else if (diff < lo)         ev = EV_FAR;
    else                        ev = EV_NONE;
    // Far goes out at once; close needs a second close in a row
    if (ev == EV_FAR)        r.action = ACT_FAR;
    else if (ev == EV_CLOSE) r.action = (prev_ev == EV_CLOSE) ? ACT_CLOSE : ACT_AGAIN;
    prev_ev      = ev;
    r.next_range = range_sel;
    return r;
  endfunction

  // Sample both channels at the rising edge: predict on input transactions,
  // check each output transaction against the oldest prediction.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni) begin
      if (in_bus.valid && in_bus.ready)
        expected_verdicts.push_back(classify_sample(cmd_e'(in_bus.command),
                                                    in_bus.ir_sample, in_bus.prox_sample));
      if (out_bus.valid && out_bus.ready) begin
        if (expected_verdicts.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: action %0d next_range %0d",
                     out_bus.action, out_bus.next_range);
        end else begin
          want = expected_verdicts.pop_front();
          if (out_bus.action !== want.action || out_bus.next_range !== want.next_range) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected action %0d next_range %0d, got %0d %0d",
                       want.action, want.next_range, out_bus.action, out_bus.next_range);
          end
        end
      end
    end
  end

  // Run-away guard
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("proximity_autorange_classifier_unit verification failed");
      $finish;
    end
  end

  // Receiver: a requested hold-off wins over the random stall pattern
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  // Offer one sample at a falling edge, idling first at random; hold it until the
  // block takes the transaction. Valid stays high on return so back-to-back
  // transactions need no idle gap.
  task automatic send_sample(input cmd_e cmd, input logic [15:0] ir, input logic [15:0] prox);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_bus.valid       <= 1'b1;
    in_bus.command     <= cmd;
    in_bus.ir_sample   <= ir;
    in_bus.prox_sample <= prox;
    do @(posedge clk_i); while (!in_bus.ready);
    items_sent++;
  endtask

  // Drop the input, then wait until every verdict is home and the pipe is empty.
  task automatic wait_for_idle();
    @(negedge clk_i);
    in_bus.valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_register(input reg_e idx, input logic [ERR_W-1:0] value);
    @(negedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk_i); while (!cfg_bus.ready);
    case (idx)
      REG_UP_SWITCH:   cfg_model.up_switch_limit   = value[ADC_W-1:0];
      REG_DOWN_SWITCH: cfg_model.down_switch_limit = value[ADC_W-1:0];
      REG_LOW_R0:      cfg_model.low_thresh_r0     = value[ADC_W-1:0];
      REG_HIGH_R0:     cfg_model.high_thresh_r0    = value[ADC_W-1:0];
      REG_LOW_R1:      cfg_model.low_thresh_r1     = value[ADC_W-1:0];
      REG_HIGH_R1:     cfg_model.high_thresh_r1    = value[ADC_W-1:0];
      REG_ERR_R0:      cfg_model.err_limit_r0      = value;
      REG_ERR_R1:      cfg_model.err_limit_r1      = value;
      default: ;
    endcase
  endtask

  task automatic write_all_registers(input cfg_t c);
    write_register(REG_UP_SWITCH,   ERR_W'(c.up_switch_limit));
    write_register(REG_DOWN_SWITCH, ERR_W'(c.down_switch_limit));
    write_register(REG_LOW_R0,      ERR_W'(c.low_thresh_r0));
    write_register(REG_HIGH_R0,     ERR_W'(c.high_thresh_r0));
    write_register(REG_LOW_R1,      ERR_W'(c.low_thresh_r1));
    write_register(REG_HIGH_R1,     ERR_W'(c.high_thresh_r1));
    write_register(REG_ERR_R0,      c.err_limit_r0);
    write_register(REG_ERR_R1,      c.err_limit_r1);
    @(negedge clk_i);
    cfg_bus.valid <= 1'b0;
  endtask

  // Mostly ordered thresholds so that classification sees every band;
  // now and then anything goes.
  function automatic cfg_t random_settings();
    int up;
    int lo0;
    int hi0;
    int lo1;
    int hi1;
    int e0;
    int e1;
    if ($urandom_range(0, 3) == 0)
      return make_thresholds($urandom_range(0, 4095), $urandom_range(0, 4095),
                             $urandom_range(0, 4095), $urandom_range(0, 4095),
                             $urandom_range(0, 4095), $urandom_range(0, 4095),
                             $urandom_range(0, 4096), $urandom_range(0, 4096));
    up  = $urandom_range(300, 3000);
    lo0 = $urandom_range(0, 3000);
    hi0 = lo0 + $urandom_range(0, 300);
    lo1 = $urandom_range(0, 400);
    hi1 = lo1 + $urandom_range(0, 100);
    e0  = hi0 + $urandom_range(0, 1000);
    e1  = hi1 + $urandom_range(0, 300);
    if (e0 > 4096) e0 = 4096;
    return make_thresholds(up, $urandom_range(0, up), lo0, hi0, lo1, hi1, e0, e1);
  endfunction

  function automatic logic [15:0] near(int centre);
    int v;
    v = centre + $urandom_range(0, 6) - 3;
    if (v < 0) v = 0;
    return 16'(v);
  endfunction

  // One poll: a leading command, then a few samples within the poll. Readings
  // cluster round the live switch limits and thresholds; some are raw noise.
  task automatic send_random_poll();
    cmd_e        cmd;
    int          n;
    int          irc;
    int          lo;
    int          hi;
    int          err;
    logic [15:0] ir;
    logic [15:0] px;
    n = $urandom_range(0, 4);
    for (int i = 0; i <= n; i++) begin
      case ($urandom_range(0, 19))
        0:       cmd = CMD_ENABLE;
        1:       cmd = CMD_UNUSED;
        2:       cmd = CMD_POLL;
        3:       cmd = CMD_FIRST;
        default: cmd = (i == 0) ? CMD_FIRST : CMD_POLL;
      endcase
      case ($urandom_range(0, 7))
        0: ir = 16'($urandom);
        1: ir = near(int'(cfg_model.up_switch_limit));
        2: ir = near(int'(cfg_model.down_switch_limit));
        3: ir = near(int'(ADC_SPAN - RANGE_MARGIN) - int'(cfg_model.high_thresh_r1));
        4: ir = 16'($urandom_range(0, 4095));
        default:
          ir = range_sel ? 16'($urandom_range(cfg_model.down_switch_limit, 4095))
                         : 16'($urandom_range(0, cfg_model.up_switch_limit));
      endcase
      irc = (ir > 16'd4095) ? 4095 : int'(ir);
      lo  = range_sel ? int'(cfg_model.low_thresh_r1)  : int'(cfg_model.low_thresh_r0);
      hi  = range_sel ? int'(cfg_model.high_thresh_r1) : int'(cfg_model.high_thresh_r0);
      err = range_sel ? int'(cfg_model.err_limit_r1)   : int'(cfg_model.err_limit_r0);
      case ($urandom_range(0, 7))
        0:       px = 16'($urandom);
        1:       px = near(irc + lo);
        2, 3:    px = near(irc + hi);
        4:       px = near(irc + err);
        5:       px = near(irc - 2);
        default: px = near(irc + (lo + hi) / 2);
      endcase
      send_sample(cmd, ir, px);
    end
  endtask

  task automatic run_polls(input int n_items);
    int target;
    target = items_sent + n_items;
    while (items_sent < target) send_random_poll();
  endtask

  // Board defaults straight out of reset: every band, clamping, both switches,
  // the one-switch-per-poll rule, close confirmation, enable and the spare code.
  task automatic check_directed_cases();
    send_sample(CMD_FIRST,  16'd0,     16'd0);      // far at range zero
    send_sample(CMD_POLL,   16'd0,     16'hFFFF);   // clamped prox, first close
    send_sample(CMD_POLL,   16'd0,     16'd4095);   // confirmed close
    send_sample(CMD_POLL,   16'd0,     16'd2450);   // in band clears the history
    send_sample(CMD_POLL,   16'd0,     16'd2600);   // close again needs a repeat
    send_sample(CMD_POLL,   16'd100,   16'd50);     // negative difference
    send_sample(CMD_POLL,   16'hFFFF,  16'hFFFF);   // clamped IR, switch up
    send_sample(CMD_POLL,   16'd0,     16'd30);     // second switch refused, far
    send_sample(CMD_POLL,   16'd3500,  16'd3560);   // above range one limit, error
    send_sample(CMD_UNUSED, 16'hFFFF,  16'd1234);   // spare code ignored
    send_sample(CMD_FIRST,  16'd100,   16'd100);    // new poll, switch down
    send_sample(CMD_POLL,   16'd1097,  16'd0);      // up switch refused
    send_sample(CMD_FIRST,  16'd1096,  16'd1096);   // on the limit: no switch
    send_sample(CMD_FIRST,  16'd1097,  16'd0);      // just over: switch up
    send_sample(CMD_FIRST,  16'd194,   16'd290);    // on the down limit: no switch; over the error limit
    send_sample(CMD_POLL,   16'd200,   16'd301);    // above range one error limit
    send_sample(CMD_ENABLE, 16'hFFFF,  16'hFFFF);   // enable forces range zero
    send_sample(CMD_POLL,   16'd2000,  16'd4095);   // switch up: the switch flag, still clear, survives enable
    send_sample(CMD_FIRST,  16'hAAAA,  16'h5555);
    send_sample(CMD_POLL,   16'h5555,  16'hAAAA);
  endtask

  // Corner settings: all zero, all max, ping-pong limits, range one limit absent,
  // range one limit suppressing the down switch, and zero-width bands.
  task automatic check_register_extremes();
    cfg_t corners[6];
    corners[0] = make_thresholds(0, 0, 0, 0, 0, 0, 0, 0);
    corners[1] = make_thresholds(4095, 4095, 4095, 4095, 4095, 4095, 4096, 4096);
    corners[2] = make_thresholds(0, 4095, 100, 200, 0, 4000, 4096, 4096);
    corners[3] = make_thresholds(1096, 4000, 2400, 2500, 95, 100, 4096, 200);
    corners[4] = make_thresholds(1096, 4000, 2400, 2500, 3000, 3596, 4096, 4096);
    corners[5] = make_thresholds(4095, 0, 0, 0, 0, 3597, 0, 4096);
    foreach (corners[k]) begin
      wait_for_idle();
      write_all_registers(corners[k]);
      run_polls(40);
    end
  endtask

  task automatic check_random_traffic(input int src_pct, input int snk_pct);
    repeat (4) begin
      wait_for_idle();
      src_idle_pct = src_pct;
      snk_idle_pct = snk_pct;
      write_all_registers(random_settings());
      run_polls(115);
    end
  endtask

  // Hold the output off for a long stretch while samples keep coming, so the
  // pipeline fills and the input stalls.
  task automatic check_output_backpressure();
    wait_for_idle();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    hold_cycles  = 150;
    run_polls(80);
  endtask

  initial begin
    in_bus.valid       = 1'b0;
    in_bus.command     = CMD_POLL;
    in_bus.ir_sample   = '0;
    in_bus.prox_sample = '0;
    cfg_bus.valid      = 1'b0;
    cfg_bus.index      = REG_UP_SWITCH;
    cfg_bus.data       = '0;
    out_bus.ready      = 1'b0;
    cfg_model          = make_thresholds(1096, 194, 2400, 2500, 95, 100, 4096, 50);
    range_sel          = 1'b0;
    switched_in_poll   = 1'b0;
    prev_ev            = EV_NONE;
    rst_ni             = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    src_idle_pct = 31;
    snk_idle_pct = 85;
    check_directed_cases();
    check_register_extremes();
    check_random_traffic(31, 85);
    check_random_traffic(85, 31);
    check_random_traffic(0, 0);
    check_output_backpressure();
    wait_for_idle();
    repeat (8) @(posedge clk_i);

    if (mismatches == 0 && expected_verdicts.size() == 0) begin
      $display("proximity_autorange_classifier_unit verification clean");
    end else begin
      $display("proximity_autorange_classifier_unit verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/pac_pkg.sv
src/pac_if.sv
src/pac_cfg_regs.sv
src/pac_classify.sv
src/proximity_autorange_classifier_unit.sv
verif/proximity_autorange_classifier_unit_tb.sv
